// ----- hdl/sha_pkg.sv -----
// Shared types and constants for the SHA-256 stream hasher.
`timescale 1ns / 1ps

package sha_pkg;

	// Block buffer geometry: 64 bytes held as 16 big-endian 32-bit words
	localparam int BUF_WORDS = 16;
	localparam int BUF_AW    = $clog2(BUF_WORDS);

	localparam logic [6:0] FILL_FULL = 7'd64;
	localparam logic [6:0] FILL_LEN  = 7'd56;
	localparam logic [7:0] PAD_BYTE  = 8'h80;

	// Buffer write port: lane_en[j] writes data[8*j +: 8]
	typedef struct packed {
		logic [3:0]        lane_en;
		logic [BUF_AW-1:0] addr;
		logic [31:0]       data;
	} sha_wr_t;

	// Top-level sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ZERO,
		ST_LEN,
		ST_START,
		ST_WAIT,
		ST_OUT
	} sha_state_t;

	// Compression engine sequencer
	typedef enum logic [1:0] {
		CORE_IDLE,
		CORE_ROUND,
		CORE_FINAL
	} sha_core_state_t;

	// Initial chaining value, H0 in the top word
	localparam logic [255:0] HASH_INIT = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	// Round constants
	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

endpackage

// ----- hdl/sha256_stream_hash_top.sv -----
// SHA-256 stream hasher: byte intake, padding sequencer and digest output.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | in_valid / in_ready  | data_byte, byte_present, end_of_message
//  output   | out_valid / out_ready| digest_word, word_index, last_word
//
// Bytes are taken only while the sequencer is idle. Each full 64-byte block then
// holds the input for its compression (start, 64 rounds on the shared round unit,
// final add). Closing a message adds padding and length writes and one or two
// compressions. The digest moves to an output buffer, so the next message is
// taken while its four words drain; a close waits only if the previous digest
// has not fully left. Reset is asynchronous and needs no clearing pass; the
// buffer RAM is never read before it is written.
`timescale 1ns / 1ps

module sha256_stream_hash_top
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] digest_word,
	output logic [1:0]  word_index,
	output logic        last_word
);

	sha_state_t state_q, state_d, ret_q, ret_d;

	logic [6:0]  fill_q, fill_d;
	logic [63:0] bits_q, bits_d;
	logic        in_fire, out_fire;
	logic        core_start, core_init, core_done, load_dig;
	sha_wr_t     wr;
	logic [BUF_AW-1:0] rd_addr;
	logic [31:0]  rd_data;
	logic [255:0] hash;
	logic [255:0] dig_q;
	logic         oval_q;
	logic [1:0]   idx_q;

	sha_buf_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	sha_round_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (core_start),
		.init    (core_init),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.done    (core_done),
		.hash    (hash)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_fire = oval_q && out_ready;

	// Sequencer: byte intake, padding, length, compression handoff
	always_comb begin
		state_d    = state_q;
		ret_d      = ret_q;
		fill_d     = fill_q;
		bits_d     = bits_q;
		wr         = '0;
		core_start = 1'b0;
		core_init  = 1'b0;
		load_dig   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (byte_present) begin
						wr.lane_en = 4'b1000 >> fill_q[1:0];
						wr.addr    = fill_q[5:2];
						wr.data    = {4{data_byte}};
						bits_d     = bits_q + 64'd8;
						if (fill_q == FILL_FULL - 7'd1) begin
							fill_d  = '0;
							ret_d   = end_of_message ? ST_PAD : ST_IDLE;
							state_d = ST_START;
						end else begin
							fill_d  = fill_q + 7'd1;
							state_d = end_of_message ? ST_PAD : ST_IDLE;
						end
					end else if (end_of_message) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				wr.lane_en = 4'b1000 >> fill_q[1:0];
				wr.addr    = fill_q[5:2];
				wr.data    = {4{PAD_BYTE}};
				fill_d     = fill_q + 7'd1;
				state_d    = ST_ZERO;
			end
			ST_ZERO: begin
				if (fill_q == FILL_LEN) begin
					state_d = ST_LEN;
				end else if (fill_q == FILL_FULL) begin
					// marker did not leave room for the length: extra block
					fill_d  = '0;
					ret_d   = ST_ZERO;
					state_d = ST_START;
				end else begin
					wr.lane_en = 4'b1000 >> fill_q[1:0];
					wr.addr    = fill_q[5:2];
					wr.data    = '0;
					fill_d     = fill_q + 7'd1;
				end
			end
			ST_LEN: begin
				if (fill_q == FILL_FULL) begin
					fill_d  = '0;
					ret_d   = ST_OUT;
					state_d = ST_START;
				end else begin
					// big-endian bit count, upper word first
					wr.lane_en = 4'b1111;
					wr.addr    = fill_q[5:2];
					wr.data    = fill_q[2] ? bits_q[31:0] : bits_q[63:32];
					fill_d     = fill_q + 7'd4;
				end
			end
			ST_START: begin
				core_start = 1'b1;
				state_d    = ST_WAIT;
			end
			ST_WAIT: begin
				if (core_done) begin
					state_d = ret_q;
				end
			end
			ST_OUT: begin
				if (!oval_q) begin
					load_dig  = 1'b1;
					core_init = 1'b1;
					bits_d    = '0;
					fill_d    = '0;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			fill_q  <= '0;
			bits_q  <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			fill_q  <= fill_d;
			bits_q  <= bits_d;
		end
	end

	// Output buffer: four words, most significant first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oval_q <= 1'b0;
			idx_q  <= '0;
		end else if (load_dig) begin
			oval_q <= 1'b1;
			idx_q  <= '0;
		end else if (out_fire) begin
			if (idx_q == 2'd3) begin
				oval_q <= 1'b0;
			end
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_dig) begin
			dig_q <= hash;
		end else if (out_fire) begin
			dig_q <= {dig_q[191:0], 64'd0};
		end
	end

	assign out_valid   = oval_q;
	assign digest_word = dig_q[255:192];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == 2'd3);

endmodule

// ----- hdl/sha_buf_ram.sv -----
// Block buffer: 16 x 32-bit synchronous RAM with byte lanes and registered read.
`timescale 1ns / 1ps

module sha_buf_ram
	import sha_pkg::*;
(
	input  logic              clk,
	input  sha_wr_t           wr,
	input  logic [BUF_AW-1:0] rd_addr,
	output logic [31:0]       rd_data
);

	logic [31:0] mem [BUF_WORDS];

	// Byte-lane write
	always_ff @(posedge clk) begin
		for (int j = 0; j < 4; j++) begin
			if (wr.lane_en[j]) begin
				mem[wr.addr][8*j +: 8] <= wr.data[8*j +: 8];
			end
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- hdl/sha_round_core.sv -----
// SHA-256 compression engine: one round per cycle, schedule words from the buffer RAM.
`timescale 1ns / 1ps

module sha_round_core
	import sha_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              init,
	output logic [BUF_AW-1:0] rd_addr,
	input  logic [31:0]       rd_data,
	output logic              done,
	output logic [255:0]      hash
);

	sha_core_state_t state_q, state_d;

	logic [5:0]  rnd_q;
	logic [31:0] hs_q [8];
	logic [31:0] v_q  [8];
	logic [31:0] w_q  [16];

	logic [31:0] w_calc, w_cur, t1, t2;
	logic [31:0] big0, big1, sig0, sig1, ch, maj;

	// Sigma functions on the current window and working state
	assign sig0 = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]}
		^ {3'b000, w_q[1][31:3]};
	assign sig1 = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
		^ {10'd0, w_q[14][31:10]};
	assign big1 = {v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
		^ {v_q[4][24:0], v_q[4][31:25]};
	assign big0 = {v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
		^ {v_q[0][21:0], v_q[0][31:22]};
	assign ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);

	// Rounds 0..15 take the word straight from RAM, later ones expand the window
	assign w_calc = w_q[0] + sig0 + w_q[9] + sig1;
	assign w_cur  = (rnd_q[5:4] == 2'd0) ? rd_data : w_calc;
	assign t1     = v_q[7] + big1 + ch + ROUND_K[rnd_q] + w_cur;
	assign t2     = big0 + maj;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			hash[255 - 32*i -: 32] = hs_q[i];
		end
	end

	// Sequencer: next state, RAM read address, done strobe
	always_comb begin
		state_d = state_q;
		rd_addr = '0;
		done    = 1'b0;
		unique case (state_q)
			CORE_IDLE: begin
				if (start) begin
					state_d = CORE_ROUND;
				end
			end
			CORE_ROUND: begin
				rd_addr = rnd_q[BUF_AW-1:0] + BUF_AW'(1);
				if (rnd_q == 6'd63) begin
					state_d = CORE_FINAL;
				end
			end
			CORE_FINAL: begin
				done    = 1'b1;
				state_d = CORE_IDLE;
			end
			default: state_d = CORE_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CORE_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Round counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q <= '0;
		end else if (state_q == CORE_ROUND) begin
			rnd_q <= rnd_q + 6'd1;
		end else begin
			rnd_q <= '0;
		end
	end

	// Chaining value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				hs_q[i] <= HASH_INIT[255 - 32*i -: 32];
			end
		end else if (init) begin
			for (int i = 0; i < 8; i++) begin
				hs_q[i] <= HASH_INIT[255 - 32*i -: 32];
			end
		end else if (state_q == CORE_FINAL) begin
			for (int i = 0; i < 8; i++) begin
				hs_q[i] <= hs_q[i] + v_q[i];
			end
		end
	end

	// Working variables and schedule window
	always_ff @(posedge clk) begin
		if (state_q == CORE_IDLE && start) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= hs_q[i];
			end
		end else if (state_q == CORE_ROUND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_cur;
		end
	end

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the SHA-256 stream hasher: byte stream in, digest words out.
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 400;
	localparam int STIM_ITEMS = 470;
	localparam logic [7:0] PAD_MARK = 8'h80;

	// SHA-256 round constants and initial chaining words
	localparam logic [31:0] SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	localparam logic [31:0] SHA_H0 [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       close;
	} byte_item_t;

	typedef struct packed {
		logic [63:0] word;
		logic [1:0]  idx;
		logic        last;
	} digest_part_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        byte_present = 1'b0;
	logic        end_of_message = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] digest_word;
	logic [1:0]  word_index;
	logic        last_word;

	byte_item_t   pending_bytes[$];
	digest_part_t digest_due[$];
	int           err_cnt = 0;
	int           cycle_cnt = 0;
	int           in_gap = 0;
	int           out_stall = 0;
	int           stim_items = 0;

	// predictor state
	logic [31:0] chain [8];
	logic [7:0]  blk [64];
	logic [63:0] msg_bits;
	int          fill;

	sha256_stream_hash_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.byte_present(byte_present),
		.end_of_message(end_of_message),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.digest_word(digest_word),
		.word_index(word_index),
		.last_word(last_word)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// one 64-round compression of blk into chain
	task automatic compress_blk();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
		int i;
		for (i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (i = 16; i < 64; i++)
			w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
				+ w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
		e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
		for (i = 0; i < 64; i++) begin
			t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
				+ SHA_K[i] + w[i];
			t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
		chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
	endtask

	task automatic hash_restart();
		int i;
		for (i = 0; i < 8; i++)
			chain[i] = SHA_H0[i];
		msg_bits = '0;
		fill = 0;
	endtask

	// absorb one accepted transaction; a close queues the four digest words
	task automatic hash_take(input byte_item_t it);
		digest_part_t part;
		int k;
		if (it.present) begin
			blk[fill] = it.data;
			fill++;
			msg_bits += 64'd8;
			if (fill == 64) begin
				compress_blk();
				fill = 0;
			end
		end
		if (it.close) begin
			blk[fill] = PAD_MARK;
			fill++;
			// no room for the length: pad out and take an extra block
			if (fill > 56) begin
				while (fill < 64) begin
					blk[fill] = 8'h00;
					fill++;
				end
				compress_blk();
				fill = 0;
			end
			while (fill < 56) begin
				blk[fill] = 8'h00;
				fill++;
			end
			for (k = 0; k < 8; k++)
				blk[56+k] = msg_bits[63-8*k -: 8];
			compress_blk();
			for (k = 0; k < 4; k++) begin
				part.word = {chain[2*k], chain[2*k+1]};
				part.idx = k[1:0];
				part.last = (k == 3);
				digest_due.push_back(part);
			end
			hash_restart();
		end
	endtask

	function automatic byte_item_t mk_item(input logic [7:0] d, input logic p, input logic c);
		byte_item_t it;
		it.data = d;
		it.present = p;
		it.close = c;
		return it;
	endfunction

	// queue one message of len bytes with random content and occasional no-op items
	task automatic queue_message(input int len);
		logic join_close;
		int i;
		join_close = (len > 0) && ($urandom_range(0, 1) == 1);
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 7) == 0) begin
				pending_bytes.push_back(mk_item(8'($urandom_range(0, 255)), 1'b0, 1'b0));
				stim_items++;
			end
			pending_bytes.push_back(mk_item(8'($urandom_range(0, 255)), 1'b1,
				join_close && (i == len - 1)));
			stim_items++;
		end
		if (!join_close) begin
			pending_bytes.push_back(mk_item(8'($urandom_range(0, 255)), 1'b0, 1'b1));
			stim_items++;
		end
	endtask

	// stimulus: directed cases, then random messages, then wait for the digests
	initial begin
		int len;
		int pick;
		hash_restart();
		// no-op item, empty message, no-op again
		pending_bytes.push_back(mk_item(8'h5a, 1'b0, 1'b0));
		pending_bytes.push_back(mk_item(8'h00, 1'b0, 1'b1));
		pending_bytes.push_back(mk_item(8'hff, 1'b0, 1'b0));
		// single byte closed on the same transaction
		pending_bytes.push_back(mk_item(8'hff, 1'b1, 1'b1));
		pending_bytes.push_back(mk_item(8'h00, 1'b1, 1'b0));
		pending_bytes.push_back(mk_item(8'h00, 1'b1, 1'b1));
		// "abc", closed by a separate empty transaction
		pending_bytes.push_back(mk_item(8'h61, 1'b1, 1'b0));
		pending_bytes.push_back(mk_item(8'h62, 1'b1, 1'b0));
		pending_bytes.push_back(mk_item(8'h63, 1'b1, 1'b0));
		pending_bytes.push_back(mk_item(8'h00, 1'b0, 1'b1));
		// empty message with a junk data byte, then a lone pad-valued byte
		pending_bytes.push_back(mk_item(8'ha5, 1'b0, 1'b1));
		pending_bytes.push_back(mk_item(8'h80, 1'b1, 1'b1));

		// random messages, biased toward padding boundaries and short lengths
		while (stim_items < STIM_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick < 3) begin
				case ($urandom_range(0, 10))
					0: len = 0;
					1: len = 1;
					2: len = 55;
					3: len = 56;
					4: len = 57;
					5: len = 63;
					6: len = 64;
					7: len = 65;
					8: len = 119;
					9: len = 120;
					default: len = 128;
				endcase
			end else if (pick < 7) begin
				len = $urandom_range(0, 12);
			end else begin
				len = $urandom_range(13, 80);
			end
			queue_message(len);
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_bytes.size() != 0 || in_valid)
			@(posedge clk);
		while (digest_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0 && digest_due.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// input driver: feeds pending_bytes, idles in bursts until the tail of the run
	always @(posedge clk or negedge arst_n) begin
		byte_item_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= 8'h00;
			byte_present <= 1'b0;
			end_of_message <= 1'b0;
			in_gap <= 0;
		end else begin
			if (in_valid && in_ready)
				hash_take(mk_item(data_byte, byte_present, end_of_message));
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_bytes.size() != 0) begin
					if (pending_bytes.size() > 60 && $urandom_range(0, 9) == 0) begin
						in_gap <= $urandom_range(0, 17);
						in_valid <= 1'b0;
					end else begin
						it = pending_bytes.pop_front();
						data_byte <= it.data;
						byte_present <= it.present;
						end_of_message <= it.close;
						in_valid <= 1'b1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor: random backpressure bursts, compares each transaction in order
	always @(posedge clk or negedge arst_n) begin
		digest_part_t exp;
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_stall <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (digest_due.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected digest word: expected none, got %h idx %0d last %0d",
						$time, digest_word, word_index, last_word);
				end else begin
					exp = digest_due.pop_front();
					if (digest_word !== exp.word) begin
						err_cnt++;
						$display("%0t: digest_word mismatch: expected %h, got %h",
							$time, exp.word, digest_word);
					end
					if (word_index !== exp.idx) begin
						err_cnt++;
						$display("%0t: word_index mismatch: expected %0d, got %0d",
							$time, exp.idx, word_index);
					end
					if (last_word !== exp.last) begin
						err_cnt++;
						$display("%0t: last_word mismatch: expected %0d, got %0d",
							$time, exp.last, last_word);
					end
				end
			end
			if (out_stall > 0) begin
				out_stall <= out_stall - 1;
				out_ready <= 1'b0;
			end else if (pending_bytes.size() > 60 && $urandom_range(0, 11) == 0) begin
				out_stall <= $urandom_range(0, 17);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

endmodule
